// ----- rtl/mcw_pkg.sv -----
// Shared definitions for the multi-channel watchdog unit.
// Holds sizes, command and state codes, channel records and the packed word layouts.
// No dependencies; every other file in rtl/ imports this package.
package mcw_pkg;

  localparam int CHANNELS   = 8;
  localparam int COUNT_BITS = 24;
  localparam int LIMIT_W    = 24;
  localparam int CMD_W      = 3;
  localparam int CHAN_W     = 3;
  localparam int ACT_W      = 3;
  localparam int TCOUNT_W   = 16;
  localparam int TOTAL_W    = 32;
  localparam int MASK_W     = 8;
  localparam int ACTIVE_W   = 4;
  localparam int STATUS_W   = 2;
  localparam int CNT_W      = $clog2(CHANNELS + 1);
  localparam int CMP_W      = ((COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W) + 3;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
  localparam logic [TCOUNT_W-1:0]   TCOUNT_MAX = '1;
  localparam logic [TOTAL_W-1:0]    TOTAL_MAX  = '1;
  localparam logic [ACTIVE_W-1:0]   ACTIVE_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK,
    CMD_REGISTER,
    CMD_UNREGISTER,
    CMD_ENABLE,
    CMD_DISABLE,
    CMD_FEED,
    CMD_FEED_ALL,
    CMD_QUERY
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OFF,
    ST_ON,
    ST_WARN,
    ST_TIMEOUT
  } chan_state_t;

  localparam logic [ACT_W-1:0] ACT_TASK_RESET = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SYS_RESET  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_GO_SAFE    = 3'd4;

  // Control part of a channel: cleared by reset.
  typedef struct packed {
    logic                  used;
    logic                  on;
    chan_state_t           st;
    logic [COUNT_BITS-1:0] elapsed;
    logic [TCOUNT_W-1:0]   tcount;
  } chan_ctl_t;

  // Settings part of a channel: written on register, no reset.
  typedef struct packed {
    logic [LIMIT_W-1:0] limit;
    logic [ACT_W-1:0]   action;
    logic               rearm;
    logic               critical;
  } chan_cfg_t;

  // What one tick does to a channel that is visited.
  typedef struct packed {
    logic                  warn;
    logic                  tmo;
    chan_state_t           st;
    logic [COUNT_BITS-1:0] elapsed;
    logic [TCOUNT_W-1:0]   tcount;
  } tick_res_t;

  // Input word, last listed field in the lowest bits.
  typedef struct packed {
    logic [6:0]         pad;
    logic               critical;
    logic               start_on;
    logic               rearm;
    logic [ACT_W-1:0]   action_code;
    logic [LIMIT_W-1:0] limit_ms;
    logic [CHAN_W-1:0]  channel;
  } in_word_t;

  // Result word, last listed field in the lowest bits.
  typedef struct packed {
    logic [2:0]          pad;
    logic [TOTAL_W-1:0]  tmo_total;
    logic [ACTIVE_W-1:0] active_count;
    logic                healthy;
    logic                safe_active;
    logic                system_reset;
    logic [MASK_W-1:0]   task_reset_mask;
    logic [MASK_W-1:0]   timeout_mask;
    logic [MASK_W-1:0]   warn_mask;
    logic [TCOUNT_W-1:0] chan_timeouts;
    logic [STATUS_W-1:0] chan_status;
    logic [CHAN_W-1:0]   slot;
    logic                ok;
  } out_word_t;

  localparam int IN_W  = $bits(in_word_t);
  localparam int OUT_W = $bits(out_word_t);

endpackage

// ----- rtl/mcw_chan_tick.sv -----
// Tick evaluation for one watchdog channel: count, warning and timeout decisions.
// Pure combinational logic; depends on mcw_pkg.
module mcw_chan_tick (
  input  mcw_pkg::chan_ctl_t ctl_i,
  input  mcw_pkg::chan_cfg_t cfg_i,
  output mcw_pkg::tick_res_t res_o
);
  import mcw_pkg::*;

  logic [COUNT_BITS-1:0] inc;
  logic [CMP_W-1:0]      e_x;
  logic [CMP_W-1:0]      l_x;
  logic [CMP_W-1:0]      e5;
  logic [CMP_W-1:0]      l4;
  chan_state_t           st1;

  always_comb begin
    inc = (ctl_i.elapsed == COUNT_MAX) ? ctl_i.elapsed : ctl_i.elapsed + COUNT_BITS'(1);
    e_x = CMP_W'(inc);
    l_x = CMP_W'(cfg_i.limit);
    e5  = (e_x << 2) + e_x;
    l4  = l_x << 2;

    // Early warning past four fifths of the limit, only from the plain enabled state.
    res_o.warn = (e5 > l4) && (ctl_i.st == ST_ON);
    st1        = res_o.warn ? ST_WARN : ctl_i.st;
    res_o.tmo  = (e_x > l_x) && (st1 != ST_TIMEOUT);

    res_o.tcount  = (res_o.tmo && ctl_i.tcount != TCOUNT_MAX) ?
                    ctl_i.tcount + TCOUNT_W'(1) : ctl_i.tcount;
    res_o.elapsed = (res_o.tmo && cfg_i.rearm) ? '0 : inc;
    if (res_o.tmo) begin
      res_o.st = cfg_i.rearm ? ST_ON : ST_TIMEOUT;
    end else begin
      res_o.st = st1;
    end
  end

endmodule

// ----- rtl/multi_channel_watchdog_unit.sv -----
// Top level of the multi-channel watchdog: handshake, channel table and result logic.
// Depends on mcw_pkg and mcw_chan_tick.
//
//   channel   ports            payload                        role
//   in_       tvalid/tready    tuser: cmd, tdata: arguments   command words
//   out_      tvalid/tready    tdata: result fields           one result per command
//
// A command word waits in the input register until the output register frees up; its result
// is then written into the output register, which drives out_tdata and out_tvalid.
// One command is accepted every cycle while out_tready does not stall the output; the rate is
// set by the single update pass over all channels.
// Reset (rst_n low at a clock edge) empties both registers and clears the channel control
// state, the counters and the safe-mode latch; channel settings are not reset. A stall on
// out_tready holds the result; the input register still takes one more word while the result waits.
module multi_channel_watchdog_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // in_tuser: cmd[2:0]
  input  logic [mcw_pkg::CMD_W-1:0]   in_tuser,
  // in_tdata: channel[2:0], limit_ms[26:3], action_code[29:27], rearm[30],
  //           start_on[31], critical[32], zero fill[39:33]
  input  logic [mcw_pkg::IN_W-1:0]    in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // out_tdata: ok[0], slot[3:1], chan_status[5:4], chan_timeouts[21:6],
  //            warn_mask[29:22], timeout_mask[37:30], task_reset_mask[45:38],
  //            system_reset[46], safe_active[47], healthy[48], active_count[52:49],
  //            tmo_total[84:53], zero fill[87:85]
  output logic [mcw_pkg::OUT_W-1:0]   out_tdata
);
  import mcw_pkg::*;

  // Input register and output register.
  logic                 s1_valid_r;
  logic [CMD_W-1:0]     s1_cmd_r;
  in_word_t             s1_data_r;
  logic                 out_valid_r;
  out_word_t            out_data_r;

  // Channel table and global state.
  chan_ctl_t            ctl_r   [CHANNELS];
  chan_ctl_t            ctl_nxt [CHANNELS];
  chan_cfg_t            cfg_r   [CHANNELS];
  logic [CHANNELS-1:0]  cfg_we;
  logic [TOTAL_W-1:0]   total_r;
  logic [TOTAL_W-1:0]   total_nxt;
  logic                 safe_r;
  logic                 safe_nxt;

  tick_res_t            tick_res [CHANNELS];
  out_word_t            res;
  logic                 advance;
  logic                 fire;

  // The output register frees up when it is empty or being read; the input register
  // moves into it on the same edge.
  assign advance    = !out_valid_r || out_tready;
  assign fire       = s1_valid_r && advance;
  assign in_tready  = !s1_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_tick
    mcw_chan_tick u_tick (
      .ctl_i (ctl_r[g]),
      .cfg_i (cfg_r[g]),
      .res_o (tick_res[g])
    );
  end

  // Command decode and next state of the whole table.
  always_comb begin
    logic [CHANNELS-1:0] sel;
    logic [CHANNELS-1:0] warn_m;
    logic [CHANNELS-1:0] tmo_m;
    logic [CHANNELS-1:0] task_m;
    logic                sys;
    logic                safe_seen;
    logic                valid;
    logic                found;
    logic [CNT_W-1:0]    tmo_cnt;
    logic [CNT_W-1:0]    active;
    logic [TOTAL_W:0]    total_sum;
    logic                healthy;

    for (int i = 0; i < CHANNELS; i++) begin
      ctl_nxt[i] = ctl_r[i];
      sel[i]     = (int'(s1_data_r.channel) == i);
    end
    cfg_we    = '0;
    total_nxt = total_r;
    safe_nxt  = safe_r;
    warn_m    = '0;
    tmo_m     = '0;
    task_m    = '0;
    sys       = 1'b0;
    safe_seen = 1'b0;
    found     = 1'b0;
    tmo_cnt   = '0;
    total_sum = '0;
    valid     = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      valid = valid | (sel[i] & ctl_r[i].used);
    end

    res      = '0;
    res.slot = s1_data_r.channel;

    case (cmd_t'(s1_cmd_r))
      CMD_TICK: begin
        res.ok = 1'b1;
        // Channels are visited in index order; once safe mode trips, only critical
        // channels are still visited for the rest of the tick.
        for (int i = 0; i < CHANNELS; i++) begin
          if (ctl_r[i].used && ctl_r[i].on && (cfg_r[i].critical || !safe_seen)) begin
            ctl_nxt[i].elapsed = tick_res[i].elapsed;
            ctl_nxt[i].st      = tick_res[i].st;
            ctl_nxt[i].tcount  = tick_res[i].tcount;
            warn_m[i]          = tick_res[i].warn;
            tmo_m[i]           = tick_res[i].tmo;
            if (tick_res[i].tmo) begin
              tmo_cnt = tmo_cnt + CNT_W'(1);
              if (cfg_r[i].action == ACT_TASK_RESET) begin
                task_m[i] = 1'b1;
              end
              if (cfg_r[i].action == ACT_SYS_RESET) begin
                sys = 1'b1;
              end
              if (cfg_r[i].action == ACT_GO_SAFE) begin
                safe_seen = 1'b1;
              end
            end
          end
        end
        if (safe_seen) begin
          safe_nxt = 1'b1;
          for (int i = 0; i < CHANNELS; i++) begin
            if (ctl_r[i].used && !cfg_r[i].critical) begin
              ctl_nxt[i].on = 1'b0;
              ctl_nxt[i].st = ST_OFF;
            end
          end
        end
        total_sum = {1'b0, total_r} + (TOTAL_W + 1)'(tmo_cnt);
        total_nxt = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
      end
      CMD_REGISTER: begin
        res.slot = '0;
        for (int i = 0; i < CHANNELS; i++) begin
          if (!found && !ctl_r[i].used) begin
            found              = 1'b1;
            ctl_nxt[i].used    = 1'b1;
            ctl_nxt[i].on      = s1_data_r.start_on;
            ctl_nxt[i].st      = s1_data_r.start_on ? ST_ON : ST_OFF;
            ctl_nxt[i].elapsed = '0;
            ctl_nxt[i].tcount  = '0;
            cfg_we[i]          = 1'b1;
            res.ok             = 1'b1;
            res.slot           = CHAN_W'(i);
          end
        end
      end
      CMD_UNREGISTER: begin
        res.ok = valid;
        for (int i = 0; i < CHANNELS; i++) begin
          if (sel[i] && ctl_r[i].used) begin
            ctl_nxt[i].used = 1'b0;
            ctl_nxt[i].on   = 1'b0;
            ctl_nxt[i].st   = ST_OFF;
          end
        end
      end
      CMD_ENABLE: begin
        res.ok = valid;
        for (int i = 0; i < CHANNELS; i++) begin
          if (sel[i] && ctl_r[i].used) begin
            ctl_nxt[i].on      = 1'b1;
            ctl_nxt[i].st      = ST_ON;
            ctl_nxt[i].elapsed = '0;
          end
        end
      end
      CMD_DISABLE: begin
        res.ok = valid;
        for (int i = 0; i < CHANNELS; i++) begin
          if (sel[i] && ctl_r[i].used) begin
            ctl_nxt[i].on = 1'b0;
            ctl_nxt[i].st = ST_OFF;
          end
        end
      end
      CMD_FEED: begin
        // Feeding is refused for a disabled or timed-out channel.
        for (int i = 0; i < CHANNELS; i++) begin
          if (sel[i] && ctl_r[i].used &&
              (ctl_r[i].st == ST_ON || ctl_r[i].st == ST_WARN)) begin
            ctl_nxt[i].elapsed = '0;
            ctl_nxt[i].st      = ST_ON;
            res.ok             = 1'b1;
          end
        end
      end
      CMD_FEED_ALL: begin
        res.ok = 1'b1;
        for (int i = 0; i < CHANNELS; i++) begin
          if (ctl_r[i].used && ctl_r[i].on &&
              (ctl_r[i].st == ST_ON || ctl_r[i].st == ST_WARN)) begin
            ctl_nxt[i].elapsed = '0;
            ctl_nxt[i].st      = ST_ON;
          end
        end
      end
      CMD_QUERY: begin
        res.ok = valid;
        for (int i = 0; i < CHANNELS; i++) begin
          if (sel[i] && ctl_r[i].used) begin
            res.chan_status   = ctl_r[i].st;
            res.chan_timeouts = ctl_r[i].tcount;
          end
        end
      end
      default: begin
        res.ok = 1'b0;
      end
    endcase

    // Masks keep only the channels that fit in the result fields.
    for (int k = 0; k < MASK_W; k++) begin
      if (k < CHANNELS) begin
        res.warn_mask[k]       = warn_m[k];
        res.timeout_mask[k]    = tmo_m[k];
        res.task_reset_mask[k] = task_m[k];
      end
    end
    res.system_reset = sys;

    // Summary fields reflect the table after this command.
    active  = '0;
    healthy = 1'b1;
    for (int i = 0; i < CHANNELS; i++) begin
      if (ctl_nxt[i].used && ctl_nxt[i].on) begin
        active = active + CNT_W'(1);
        if (ctl_nxt[i].st == ST_TIMEOUT) begin
          healthy = 1'b0;
        end
      end
    end
    res.active_count = (int'(active) > int'(ACTIVE_MAX)) ? ACTIVE_MAX :
                       ACTIVE_W'(active);
    res.healthy      = healthy;
    res.safe_active  = safe_nxt;
    res.tmo_total    = total_nxt;
  end

  // Handshake registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_cmd_r  <= in_tuser;
      s1_data_r <= in_word_t'(in_tdata);
    end
    if (fire) begin
      out_data_r <= res;
    end
  end

  // Channel control state, counters and the safe-mode latch.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        ctl_r[i] <= '0;
      end
      total_r <= '0;
      safe_r  <= 1'b0;
    end else if (fire) begin
      for (int i = 0; i < CHANNELS; i++) begin
        ctl_r[i] <= ctl_nxt[i];
      end
      total_r <= total_nxt;
      safe_r  <= safe_nxt;
    end
  end

  // Channel settings, written only when a slot is allocated.
  always_ff @(posedge clk) begin
    for (int i = 0; i < CHANNELS; i++) begin
      if (fire && cfg_we[i]) begin
        cfg_r[i].limit    <= s1_data_r.limit_ms;
        cfg_r[i].action   <= s1_data_r.action_code;
        cfg_r[i].rearm    <= s1_data_r.rearm;
        cfg_r[i].critical <= s1_data_r.critical;
      end
    end
  end

`ifndef SYNTH
  // Safe mode, once latched, stays until reset.
  a_safe_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> !$fell(safe_r))
    else $error("safe-mode latch cleared without reset");

  // The total timeout counter only counts up.
  a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> (total_r >= $past(total_r)))
    else $error("total timeout counter went down");

  // A task reset is only requested for a channel that timed out.
  a_task_in_timeout: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r.task_reset_mask & ~out_data_r.timeout_mask) == '0))
    else $error("task reset without timeout");

  // A result that reports timeouts comes from a tick, which is always accepted.
  a_timeout_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.timeout_mask != '0) |-> out_data_r.ok)
    else $error("timeouts reported on a refused command");
`endif

endmodule

// ----- test/multi_channel_watchdog_unit_test.sv -----
// Self-checking test of multi_channel_watchdog_unit: command words go in, and every result
// word is checked against a channel-table model kept inside this test.
// Depends on mcw_pkg and the RTL under rtl/ only.
`timescale 1ns / 1ps

module multi_channel_watchdog_unit_test;
  import mcw_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_WORDS = 155;

  // Action codes that the package leaves unnamed.
  localparam logic [ACT_W-1:0] ACT_NONE      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_LOG       = 3'd1;
  localparam logic [ACT_W-1:0] ACT_CUSTOM    = 3'd5;
  localparam logic [ACT_W-1:0] ACT_UNDEFINED = 3'd7;

  typedef struct {
    cmd_t     cmd;
    in_word_t args;
  } command_word_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [CMD_W-1:0] in_tuser = '0;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  multi_channel_watchdog_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  command_word_t pending_words[$];
  out_word_t     expected_results[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned stall_left = 0;
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned results_checked = 0;
  int unsigned ticks_sent = 0;
  int unsigned cycles = 0;

  // Model of the channel table.
  bit                    ch_used     [CHANNELS];
  bit                    ch_on       [CHANNELS];
  chan_state_t           ch_st       [CHANNELS];
  logic [COUNT_BITS-1:0] ch_elapsed  [CHANNELS];
  logic [LIMIT_W-1:0]    ch_limit    [CHANNELS];
  logic [ACT_W-1:0]      ch_action   [CHANNELS];
  bit                    ch_rearm    [CHANNELS];
  bit                    ch_critical [CHANNELS];
  logic [TCOUNT_W-1:0]   ch_tcount   [CHANNELS];
  logic [TOTAL_W-1:0]    total_tmo;
  bit                    safe_latched;

  function automatic void clear_watchdog_model();
    for (int i = 0; i < CHANNELS; i++) begin
      ch_used[i]     = 1'b0;
      ch_on[i]       = 1'b0;
      ch_st[i]       = ST_OFF;
      ch_elapsed[i]  = '0;
      ch_limit[i]    = '0;
      ch_action[i]   = ACT_NONE;
      ch_rearm[i]    = 1'b0;
      ch_critical[i] = 1'b0;
      ch_tcount[i]   = '0;
    end
    total_tmo    = '0;
    safe_latched = 1'b0;
  endfunction

  // Safe mode turns off every registered channel that is not critical.
  function automatic void enter_safe_mode();
    safe_latched = 1'b1;
    for (int j = 0; j < CHANNELS; j++) begin
      if (ch_used[j] && !ch_critical[j]) begin
        ch_on[j] = 1'b0;
        ch_st[j] = ST_OFF;
      end
    end
  endfunction

  function automatic bit feed_channel(int c);
    if (ch_st[c] != ST_ON && ch_st[c] != ST_WARN) return 1'b0;
    ch_elapsed[c] = '0;
    ch_st[c]      = ST_ON;
    return 1'b1;
  endfunction

  // Applies one command to the model and returns the result word it should produce.
  function automatic out_word_t predict_result(cmd_t cmd, in_word_t a);
    out_word_t   r;
    int unsigned active;
    bit          healthy;
    bit          placed;
    int          c;
    r = '0;
    c = int'(a.channel);
    r.slot = a.channel;
    case (cmd)
      CMD_TICK: begin
        ticks_sent++;
        r.ok = 1'b1;
        // Channels are visited in index order; one that safe mode turns off earlier in the
        // same tick is skipped.
        for (int i = 0; i < CHANNELS; i++) begin
          if (ch_used[i] && ch_on[i]) begin
            if (ch_elapsed[i] != COUNT_MAX) ch_elapsed[i]++;
            if (longint'(ch_elapsed[i]) * 5 > longint'(ch_limit[i]) * 4 && ch_st[i] == ST_ON) begin
              ch_st[i] = ST_WARN;
              r.warn_mask[i] = 1'b1;
            end
            if (ch_elapsed[i] > ch_limit[i] && ch_st[i] != ST_TIMEOUT) begin
              ch_st[i] = ST_TIMEOUT;
              if (ch_tcount[i] != TCOUNT_MAX) ch_tcount[i]++;
              if (total_tmo != TOTAL_MAX) total_tmo++;
              r.timeout_mask[i] = 1'b1;
              case (ch_action[i])
                ACT_TASK_RESET: r.task_reset_mask[i] = 1'b1;
                ACT_SYS_RESET:  r.system_reset = 1'b1;
                ACT_GO_SAFE:    enter_safe_mode();
                default: ;
              endcase
              // Re-arm restarts the count, but a channel that safe mode turned off stays off.
              if (ch_rearm[i]) begin
                ch_elapsed[i] = '0;
                if (ch_on[i]) ch_st[i] = ST_ON;
              end
            end
          end
        end
      end
      CMD_REGISTER: begin
        r.slot = '0;
        placed = 1'b0;
        for (int i = 0; i < CHANNELS; i++) begin
          if (!placed && !ch_used[i]) begin
            placed         = 1'b1;
            ch_used[i]     = 1'b1;
            ch_limit[i]    = a.limit_ms;
            ch_action[i]   = a.action_code;
            ch_rearm[i]    = a.rearm;
            ch_on[i]       = a.start_on;
            ch_critical[i] = a.critical;
            ch_st[i]       = a.start_on ? ST_ON : ST_OFF;
            ch_elapsed[i]  = '0;
            ch_tcount[i]   = '0;
            r.ok           = 1'b1;
            r.slot         = CHAN_W'(i);
          end
        end
      end
      CMD_UNREGISTER: begin
        if (ch_used[c]) begin
          ch_used[c] = 1'b0;
          ch_on[c]   = 1'b0;
          ch_st[c]   = ST_OFF;
          r.ok       = 1'b1;
        end
      end
      CMD_ENABLE: begin
        if (ch_used[c]) begin
          ch_on[c]      = 1'b1;
          ch_st[c]      = ST_ON;
          ch_elapsed[c] = '0;
          r.ok          = 1'b1;
        end
      end
      CMD_DISABLE: begin
        if (ch_used[c]) begin
          ch_on[c] = 1'b0;
          ch_st[c] = ST_OFF;
          r.ok     = 1'b1;
        end
      end
      CMD_FEED: begin
        if (ch_used[c] && feed_channel(c)) r.ok = 1'b1;
      end
      CMD_FEED_ALL: begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (ch_used[i] && ch_on[i]) void'(feed_channel(i));
        end
        r.ok = 1'b1;
      end
      default: begin
        if (ch_used[c]) begin
          r.ok            = 1'b1;
          r.chan_status   = ch_st[c];
          r.chan_timeouts = ch_tcount[c];
        end
      end
    endcase

    active  = 0;
    healthy = 1'b1;
    for (int i = 0; i < CHANNELS; i++) begin
      if (ch_used[i] && ch_on[i]) begin
        active++;
        if (ch_st[i] == ST_TIMEOUT) healthy = 1'b0;
      end
    end
    r.safe_active  = safe_latched;
    r.healthy      = healthy;
    r.active_count = (active > ACTIVE_MAX) ? ACTIVE_MAX : ACTIVE_W'(active);
    r.tmo_total    = total_tmo;
    return r;
  endfunction

  function automatic command_word_t make_word(cmd_t c, int unsigned ch);
    command_word_t w;
    w.cmd          = c;
    w.args         = '0;
    w.args.channel = CHAN_W'(ch);
    return w;
  endfunction

  function automatic command_word_t make_register(logic [LIMIT_W-1:0] lim,
                                                  logic [ACT_W-1:0] act,
                                                  bit rearm, bit start_on, bit critical);
    command_word_t w;
    w.cmd              = CMD_REGISTER;
    w.args             = '0;
    w.args.limit_ms    = lim;
    w.args.action_code = act;
    w.args.rearm       = rearm;
    w.args.start_on    = start_on;
    w.args.critical    = critical;
    return w;
  endfunction

  // Mostly short limits so that warnings and timeouts come often; ticks dominate.
  function automatic command_word_t random_command(bit allow_safe);
    command_word_t w;
    int unsigned   pick;
    w.args         = '0;
    w.args.channel = CHAN_W'($urandom_range(CHANNELS - 1));
    pick = $urandom_range(99);
    if (pick < 70)      w.args.limit_ms = LIMIT_W'($urandom_range(12));
    else if (pick < 85) w.args.limit_ms = LIMIT_W'($urandom_range(40));
    else if (pick < 95) w.args.limit_ms = LIMIT_W'($urandom);
    else                w.args.limit_ms = '1;
    w.args.action_code = ACT_W'($urandom_range(7));
    if (!allow_safe && w.args.action_code == ACT_GO_SAFE) w.args.action_code = ACT_TASK_RESET;
    w.args.rearm    = ($urandom_range(1) != 0);
    w.args.start_on = ($urandom_range(3) != 0);
    w.args.critical = ($urandom_range(1) != 0);
    pick = $urandom_range(99);
    if (pick < 38)      w.cmd = CMD_TICK;
    else if (pick < 48) w.cmd = CMD_REGISTER;
    else if (pick < 54) w.cmd = CMD_UNREGISTER;
    else if (pick < 62) w.cmd = CMD_ENABLE;
    else if (pick < 67) w.cmd = CMD_DISABLE;
    else if (pick < 80) w.cmd = CMD_FEED;
    else if (pick < 85) w.cmd = CMD_FEED_ALL;
    else                w.cmd = CMD_QUERY;
    return w;
  endfunction

  // Command driver: the model is updated at the edge where a word is taken.
  always @(posedge clk) begin : drive_commands
    command_word_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      clear_watchdog_model();
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(predict_result(cmd_t'(in_tuser), in_word_t'(in_tdata)));
        words_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_words.pop_front();
          in_tuser  <= nxt.cmd;
          in_tdata  <= nxt.args;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here so the result side can fill the block up.
  always @(posedge clk) begin
    if (!rst_n) stall_left <= 0;
    else if (hold_req) stall_left <= HOLD_CYCLES;
    else if (stall_left != 0) stall_left <= stall_left - 1;
  end

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Result monitor: compares every accepted word with the oldest prediction.
  always @(posedge clk) begin : watch_results
    out_word_t want;
    out_word_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_results.size() == 0) begin
          $error("result word %h arrived with no command outstanding", out_tdata);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("ok", want.ok, got.ok);
          check_field("slot", want.slot, got.slot);
          check_field("chan_status", want.chan_status, got.chan_status);
          check_field("chan_timeouts", want.chan_timeouts, got.chan_timeouts);
          check_field("warn_mask", want.warn_mask, got.warn_mask);
          check_field("timeout_mask", want.timeout_mask, got.timeout_mask);
          check_field("task_reset_mask", want.task_reset_mask, got.task_reset_mask);
          check_field("system_reset", want.system_reset, got.system_reset);
          check_field("safe_active", want.safe_active, got.safe_active);
          check_field("healthy", want.healthy, got.healthy);
          check_field("active_count", want.active_count, got.active_count);
          check_field("tmo_total", want.tmo_total, got.tmo_total);
          check_field("zero fill", want.pad, got.pad);
          results_checked++;
        end
      end
      out_tready <= (stall_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("cycle limit reached with %0d results outstanding", expected_results.size());
      $display("multi_channel_watchdog_unit_test: FAIL");
      $finish;
    end
  end

  // Sender pause: returns once every queued word is taken and every result is back.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_tvalid || expected_results.size() != 0);
  endtask

  task automatic run_phase(int unsigned send_pct, int unsigned recv_pct, bit allow_safe,
                           bit long_hold);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < PHASE_WORDS; i++) pending_words.push_back(random_command(allow_safe));
    if (long_hold) begin
      hold_req = 1'b1;
      @(negedge clk);
      hold_req = 1'b0;
    end
    wait_drained();
  endtask

  initial begin : run_test
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty table: targeted commands are refused, tick and feed all still succeed.
    pending_words.push_back(make_word(CMD_QUERY, 0));
    pending_words.push_back(make_word(CMD_FEED, 3));
    pending_words.push_back(make_word(CMD_ENABLE, 5));
    pending_words.push_back(make_word(CMD_TICK, 0));
    pending_words.push_back(make_word(CMD_FEED_ALL, 0));
    // Limit zero times out on the first tick; the largest limit never does.
    pending_words.push_back(make_register('0, ACT_TASK_RESET, 1'b0, 1'b1, 1'b0));
    pending_words.push_back(make_register('1, ACT_SYS_RESET, 1'b1, 1'b1, 1'b1));
    pending_words.push_back(make_register(24'd5, ACT_SYS_RESET, 1'b1, 1'b0, 1'b1));
    pending_words.push_back(make_register(24'd2, ACT_UNDEFINED, 1'b0, 1'b1, 1'b0));
    pending_words.push_back(make_register(24'd3, ACT_LOG, 1'b1, 1'b1, 1'b0));
    pending_words.push_back(make_register(24'd1, ACT_CUSTOM, 1'b1, 1'b1, 1'b1));
    pending_words.push_back(make_register(24'd4, ACT_NONE, 1'b0, 1'b1, 1'b1));
    pending_words.push_back(make_register(24'd7, ACT_TASK_RESET, 1'b1, 1'b0, 1'b0));
    // Table is full now, so this one is refused.
    pending_words.push_back(make_register(24'd9, ACT_LOG, 1'b0, 1'b1, 1'b0));
    pending_words.push_back(make_word(CMD_TICK, 0));
    pending_words.push_back(make_word(CMD_FEED, 0));
    pending_words.push_back(make_word(CMD_QUERY, 0));
    pending_words.push_back(make_word(CMD_ENABLE, 0));
    pending_words.push_back(make_word(CMD_ENABLE, 2));
    pending_words.push_back(make_word(CMD_TICK, 0));
    // Channel 3 is in warning here; feeding it brings it back to enabled.
    pending_words.push_back(make_word(CMD_FEED, 3));
    pending_words.push_back(make_word(CMD_DISABLE, 7));
    pending_words.push_back(make_word(CMD_UNREGISTER, 6));
    pending_words.push_back(make_word(CMD_QUERY, 6));
    wait_drained();

    // Safe mode latches for good, so it is held back until the later phases.
    run_phase(0, 0, 1'b0, 1'b1);
    run_phase(54, 0, 1'b0, 1'b0);
    // A non-critical channel with limit zero enters safe mode on the next tick.
    pending_words.push_back(make_word(CMD_UNREGISTER, 7));
    pending_words.push_back(make_register('0, ACT_GO_SAFE, 1'b1, 1'b1, 1'b0));
    pending_words.push_back(make_word(CMD_TICK, 0));
    run_phase(0, 54, 1'b1, 1'b0);
    run_phase(37, 37, 1'b1, 1'b0);

    repeat (8) @(posedge clk);
    $display("Sent %0d command words (%0d ticks), checked %0d result words.",
             words_sent, ticks_sent, results_checked);
    $display("Channel timeouts seen: %0d, safe mode reached: %0d.", total_tmo, safe_latched);
    if (mismatches == 0) begin
      $display("multi_channel_watchdog_unit_test: PASS");
    end else begin
      $display("multi_channel_watchdog_unit_test: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/mcw_pkg.sv
rtl/mcw_chan_tick.sv
rtl/multi_channel_watchdog_unit.sv
test/multi_channel_watchdog_unit_test.sv
